[hw/rtl/lik_pkg.sv]
// Shared types, widths and constants for the leg inverse kinematics pipeline.
// Used by the root cell, the rotation cell and the top level; no dependencies.
package lik_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int CORDIC_ITERATIONS_DEF = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int PRESHIFT = 8;
	// Squared sums (r^2, 4L^2) and their roots.
	localparam int SUM_W = 2 * COORD_WIDTH + 2;
	localparam int ROOT_W = SUM_W / 2;
	// Rotation datapath and angle accumulator, signed.
	localparam int PATH_W = ROOT_W + PRESHIFT + 3;
	localparam int ANG_W = 28;

	localparam logic [14:0] LINK_RESET = 15'd1638;

	localparam logic signed [ANG_W-1:0] ANG_QUARTER_PI = ANG_W'(13176795);
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(26353589);

	localparam logic [ANG_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
		ANG_W'(13176795), ANG_W'(7778716), ANG_W'(4110060), ANG_W'(2086331),
		ANG_W'(1047214), ANG_W'(524117), ANG_W'(262123), ANG_W'(131069),
		ANG_W'(65536), ANG_W'(32768), ANG_W'(16384), ANG_W'(8192),
		ANG_W'(4096), ANG_W'(2048), ANG_W'(1024), ANG_W'(512),
		ANG_W'(256), ANG_W'(128), ANG_W'(64), ANG_W'(32),
		ANG_W'(16), ANG_W'(8), ANG_W'(4), ANG_W'(2)
	};

	typedef struct packed {
		logic [1:0] leg;
		logic signed [COORD_WIDTH-1:0] foot_x;
		logic signed [COORD_WIDTH-1:0] foot_y;
		logic signed [COORD_WIDTH-1:0] foot_z;
	} lik_in_t;

	typedef struct packed {
		logic [1:0] leg_out;
		logic signed [15:0] motor_abduction;
		logic signed [15:0] motor_hip;
		logic signed [15:0] motor_knee;
		logic status;
	} lik_out_t;

endpackage

[hw/rtl/leg_inverse_kinematics_drive_top.sv]
// Timing: done is start delayed through the valid chain, which matches the registered front end,
// the root cell chain, the rotation cell chain and the output register.
// Throughput: one beat per cycle; busy is always low and every stage advances each cycle.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
// Reset clears the valid chain and loads link_q with 1638; payload is not reset.
// Depends on lik_pkg, lik_sqrt_cell and lik_cordic_cell.
module leg_inverse_kinematics_drive_top import lik_pkg::*; #(
	parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  lik_in_t cmd,
	input  logic link_we,
	input  logic [14:0] link_wdata,
	output logic done,
	output lik_out_t result
);

	localparam int CW = COORD_WIDTH;
	localparam int N = ROOT_W;
	localparam int M = CORDIC_ITERATIONS;
	localparam int LAT = N + M + 4;

	typedef struct packed {
		logic [1:0] leg;
		logic sx;
		logic sy;
		logic sz;
		logic [CW-1:0] ax;
		logic [CW-1:0] ay;
		logic [CW-1:0] az;
		logic status;
	} side_t;

	typedef struct packed {
		logic [1:0] leg;
		logic sy;
		logic flip;
		logic status;
		logic [2:0] num0;
		logic [2:0] den0;
	} ang_side_t;

	logic [14:0] link_q;
	logic [LAT-1:0] vld_q;

	lik_in_t in_s1;
	side_t side_s2;
	side_t side_nx;
	side_t side_s3;
	logic [2*CW-1:0] ax2_s2, ay2_s2, az2_s2;
	logic [29:0] l2_s2;
	logic [SUM_W-1:0] sq_in_s3 [3];

	side_t sq_side_q [N];
	ang_side_t cd_side_q [M];
	ang_side_t entry_side;

	logic [SUM_W-1:0] sq_v [3][N+1];
	logic [SUM_W-1:0] sq_r [3][N+1];
	logic [ROOT_W-1:0] root [3];
	logic [ROOT_W-1:0] num [3];
	logic [ROOT_W-1:0] den [3];

	logic signed [PATH_W-1:0] cx [3][M+1];
	logic signed [PATH_W-1:0] cy [3][M+1];
	logic signed [ANG_W-1:0] ca [3][M+1];

	logic [CW-1:0] ax, ay, az;
	logic [SUM_W-1:0] xz2, r2, fl2;
	logic reach;

	lik_out_t res_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= LINK_RESET;
			vld_q <= '0;
		end else begin
			if (link_we) begin
				link_q <= link_wdata;
			end
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	// Front end: magnitudes, squares, then sums and the reach test.
	assign ax = in_s1.foot_x[CW-1] ? CW'(-in_s1.foot_x) : CW'(in_s1.foot_x);
	assign ay = in_s1.foot_y[CW-1] ? CW'(-in_s1.foot_y) : CW'(in_s1.foot_y);
	assign az = in_s1.foot_z[CW-1] ? CW'(-in_s1.foot_z) : CW'(in_s1.foot_z);

	assign xz2 = SUM_W'(ax2_s2) + SUM_W'(az2_s2);
	assign r2 = xz2 + SUM_W'(ay2_s2);
	assign fl2 = SUM_W'({l2_s2, 2'b00});
	assign reach = r2 <= fl2;

	always_comb begin
		side_nx = side_s2;
		side_nx.status = (r2 == '0) || !reach || (side_s2.ax == '0 && side_s2.az == '0);
	end

	always_ff @(posedge clk) begin
		in_s1 <= cmd;
		ax2_s2 <= ax * ax;
		ay2_s2 <= ay * ay;
		az2_s2 <= az * az;
		l2_s2 <= link_q * link_q;
		side_s2.leg <= in_s1.leg;
		side_s2.sx <= in_s1.foot_x[CW-1];
		side_s2.sy <= in_s1.foot_y[CW-1];
		side_s2.sz <= in_s1.foot_z[CW-1];
		side_s2.ax <= ax;
		side_s2.ay <= ay;
		side_s2.az <= az;
		side_s2.status <= 1'b0;
		sq_in_s3[0] <= reach ? fl2 - r2 : '0;
		sq_in_s3[1] <= r2;
		sq_in_s3[2] <= xz2;
		side_s3 <= side_nx;
	end

	// Three root chains: h from 4L^2 - r^2, r from r^2, rho from x^2 + z^2.
	for (genvar l = 0; l < 3; l++) begin : g_root
		assign sq_v[l][0] = sq_in_s3[l];
		assign sq_r[l][0] = '0;
		for (genvar k = 0; k < N; k++) begin : g_cell
			lik_sqrt_cell #(.BITPOS(N - 1 - k)) u_cell (
				.clk(clk),
				.rem_in(sq_v[l][k]),
				.root_in(sq_r[l][k]),
				.rem_out(sq_v[l][k+1]),
				.root_out(sq_r[l][k+1])
			);
		end
		assign root[l] = sq_r[l][N][ROOT_W-1:0];
	end

	always_ff @(posedge clk) begin
		sq_side_q[0] <= side_s3;
		for (int k = 1; k < N; k++) begin
			sq_side_q[k] <= sq_side_q[k-1];
		end
	end

	// Angle lanes: hip/knee term atan2(h, r), asin term atan2(|y|, rho),
	// abduction atan2(|x|, |z|).
	assign num[0] = root[0];
	assign den[0] = root[1];
	assign num[1] = ROOT_W'(sq_side_q[N-1].ay);
	assign den[1] = root[2];
	assign num[2] = ROOT_W'(sq_side_q[N-1].ax);
	assign den[2] = ROOT_W'(sq_side_q[N-1].az);

	always_comb begin
		entry_side.leg = sq_side_q[N-1].leg;
		entry_side.sy = sq_side_q[N-1].sy;
		entry_side.flip = sq_side_q[N-1].sx ^ sq_side_q[N-1].sz;
		entry_side.status = sq_side_q[N-1].status;
		for (int l = 0; l < 3; l++) begin
			entry_side.num0[l] = num[l] == '0;
			entry_side.den0[l] = den[l] == '0;
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_ang
		assign cx[l][0] = PATH_W'({den[l], {PRESHIFT{1'b0}}});
		assign cy[l][0] = PATH_W'({num[l], {PRESHIFT{1'b0}}});
		assign ca[l][0] = '0;
		for (genvar j = 0; j < M; j++) begin : g_cell
			lik_cordic_cell #(.STAGE(j)) u_cell (
				.clk(clk),
				.px_in(cx[l][j]),
				.py_in(cy[l][j]),
				.acc_in(ca[l][j]),
				.px_out(cx[l][j+1]),
				.py_out(cy[l][j+1]),
				.acc_out(ca[l][j+1])
			);
		end
	end

	always_ff @(posedge clk) begin
		cd_side_q[0] <= entry_side;
		for (int j = 1; j < M; j++) begin
			cd_side_q[j] <= cd_side_q[j-1];
		end
	end

	// Back end: special operands, clamp, combine, round and saturate.
	function automatic logic signed [ANG_W-1:0] fix_angle(
		input logic signed [ANG_W-1:0] acc,
		input logic num0,
		input logic den0
	);
		logic signed [ANG_W-1:0] v;
		if (num0) begin
			v = '0;
		end else if (den0) begin
			v = ANG_HALF_PI;
		end else if (acc < 0) begin
			v = '0;
		end else if (acc > ANG_HALF_PI) begin
			v = ANG_HALF_PI;
		end else begin
			v = acc;
		end
		return v;
	endfunction

	function automatic logic signed [15:0] to_q13(input logic signed [ANG_W+1:0] v);
		logic signed [ANG_W+1:0] t;
		logic signed [ANG_W-10:0] q;
		logic signed [15:0] o;
		t = v + (ANG_W+2)'(1024);
		q = (ANG_W-9)'(t >>> 11);
		if (q > (ANG_W-9)'(32767)) begin
			o = 16'sh7FFF;
		end else if (q < -(ANG_W-9)'(32768)) begin
			o = 16'sh8000;
		end else begin
			o = 16'(q);
		end
		return o;
	endfunction

	logic signed [ANG_W+1:0] a0, a1, a2, abd_w, hip_w, knee_w;
	ang_side_t fin;

	assign fin = cd_side_q[M-1];

	always_comb begin
		a0 = (ANG_W+2)'(fix_angle(ca[0][M], fin.num0[0], fin.den0[0]));
		a1 = (ANG_W+2)'(fix_angle(ca[1][M], fin.num0[1], fin.den0[1]));
		a2 = (ANG_W+2)'(fix_angle(ca[2][M], fin.num0[2], fin.den0[2]));
		abd_w = fin.flip ? a2 : -a2;
		hip_w = (ANG_W+2)'(ANG_QUARTER_PI) - ((fin.sy ? -a1 : a1) + a0);
		knee_w = (a0 <<< 1) - (ANG_W+2)'(ANG_HALF_PI);
	end

	always_ff @(posedge clk) begin
		res_q.leg_out <= fin.leg;
		res_q.motor_abduction <= to_q13(abd_w);
		res_q.motor_hip <= to_q13(hip_w);
		res_q.motor_knee <= to_q13(knee_w);
		res_q.status <= fin.status;
	end

	assign result = res_q;
	assign done = vld_q[LAT-1];

`ifndef SYNTHESIS
	a_knee_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.motor_knee >= -16'sd12868 && result.motor_knee <= 16'sd12868))
		else $error("knee command outside the bent range");
	a_abd_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.motor_abduction >= -16'sd12868 &&
		result.motor_abduction <= 16'sd12868))
		else $error("abduction command beyond a quarter turn");
	a_reach_root: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[N+2] && !sq_side_q[N-1].status) |-> root[1] != '0)
		else $error("reachable target with zero radius");
`endif

endmodule

[hw/rtl/lik_sqrt_cell.sv]
// One digit cell of the pipelined integer square root.
// Depends on lik_pkg for the operand width.
module lik_sqrt_cell import lik_pkg::*; #(
	parameter int BITPOS = 0
) (
	input  logic clk,
	input  logic [SUM_W-1:0] rem_in,
	input  logic [SUM_W-1:0] root_in,
	output logic [SUM_W-1:0] rem_out,
	output logic [SUM_W-1:0] root_out
);

	localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * BITPOS);

	logic [SUM_W-1:0] trial;
	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] root_q;

	assign trial = root_in + BIT;

	always_ff @(posedge clk) begin
		if (rem_in >= trial) begin
			rem_q <= rem_in - trial;
			root_q <= (root_in >> 1) + BIT;
		end else begin
			rem_q <= rem_in;
			root_q <= root_in >> 1;
		end
	end

	assign rem_out = rem_q;
	assign root_out = root_q;

endmodule

[hw/rtl/lik_cordic_cell.sv]
// One vectoring rotation step of the angle pipeline.
// Depends on lik_pkg for widths and the arctangent table.
module lik_cordic_cell import lik_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic clk,
	input  logic signed [PATH_W-1:0] px_in,
	input  logic signed [PATH_W-1:0] py_in,
	input  logic signed [ANG_W-1:0] acc_in,
	output logic signed [PATH_W-1:0] px_out,
	output logic signed [PATH_W-1:0] py_out,
	output logic signed [ANG_W-1:0] acc_out
);

	localparam logic signed [ANG_W-1:0] STEP = ATAN_TAB[STAGE];

	logic signed [PATH_W-1:0] px_q;
	logic signed [PATH_W-1:0] py_q;
	logic signed [ANG_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (!py_in[PATH_W-1]) begin
			px_q <= px_in + (py_in >>> STAGE);
			py_q <= py_in - (px_in >>> STAGE);
			acc_q <= acc_in + STEP;
		end else begin
			px_q <= px_in - (py_in >>> STAGE);
			py_q <= py_in + (px_in >>> STAGE);
			acc_q <= acc_in - STEP;
		end
	end

	assign px_out = px_q;
	assign py_out = py_q;
	assign acc_out = acc_q;

endmodule
